// File: rtl/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

	// letter codes, a=0 through z=25
	typedef logic [4:0] letter_t;
	// row or column inside the square, one past the end marks a full square
	typedef logic [2:0] coord_t;
	typedef logic [1:0] req_t;

	localparam int SQ_CELLS = 25;
	localparam int ALPHA_N  = 26;

	localparam letter_t LET_I     = 5'd8;
	localparam letter_t LET_J     = 5'd9;
	localparam letter_t LET_X     = 5'd23;
	localparam letter_t LET_Z     = 5'd25;
	localparam letter_t LET_LIMIT = 5'd26;

	localparam coord_t SIDE      = 3'd5;
	localparam coord_t SIDE_LAST = 3'd4;

	localparam req_t REQ_KEY    = 2'd0;
	localparam req_t REQ_FINISH = 2'd1;
	localparam req_t REQ_PAIR   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_POS,
		ST_CELL
	} state_t;

	typedef struct packed {
		coord_t row;
		coord_t col;
	} pos_t;

	// one write into the square and the letter position table
	typedef struct packed {
		logic    en;
		letter_t letter;
		coord_t  row;
		coord_t  col;
	} place_t;

	// step one place with wrap inside the square
	function automatic coord_t next_coord(coord_t v);
		return (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
	endfunction

	// linear cell index row*5+col
	function automatic letter_t cell_idx(coord_t r, coord_t c);
		letter_t r5;
		r5 = {2'b00, r};
		return (r5 << 2) + r5 + {2'b00, c};
	endfunction

endpackage

`default_nettype wire

// File: rtl/playfair_digraph_encrypt.sv
`default_nettype none

// Playfair encryption on a 5x5 key square.
// Input: an item is taken at a clock edge with start high and busy low.
//   req_type key letter: j counts as i, the letter is appended if unused and
//   the square is neither full nor finished; no result, busy stays low.
//   req_type finish: busy is high while the sweep walks a..z and
//   appends every unused letter except j; the square is then ready.
//   req_type encrypt pair: one result. With the square ready the item passes
//   a position read, then a square read, then the output register; busy is
//   high in the ST_POS and ST_CELL states. Before finish the result shows in
//   the next cycle with status 1 and zero letters, busy stays low.
// Output: done is high for exactly one cycle with cipher_first, cipher_second
//   and status valid; the receiver cannot stall, so nothing is held back.
// Throughput: one key letter per cycle while busy is low; a new pair waits
//   for the two reads in series through the position and square memories.
// Reset: the square is empty and not ready; no memory clearing is needed.
module playfair_digraph_encrypt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pfe_pkg::req_t    req_type,
	input  pfe_pkg::letter_t letter_first,
	input  pfe_pkg::letter_t letter_second,
	input  logic             second_present,
	output logic             done,
	output pfe_pkg::letter_t cipher_first,
	output pfe_pkg::letter_t cipher_second,
	output logic             status
);
	import pfe_pkg::*;

	state_t  state_q, state_next;
	letter_t sweep_q;
	coord_t  fill_row_q, fill_col_q;
	logic [ALPHA_N-1:0] used_q;
	logic    ready_q;
	logic    done_q, status_q;
	letter_t cipher_first_q, cipher_second_q;

	logic    accept, full;
	letter_t key_letter, cand;
	logic    cand_en;
	place_t  place;
	letter_t a_clamp, b_clamp, b_pad, a_addr, b_addr;
	pos_t    pos_a, pos_b;
	letter_t sq_idx_a, sq_idx_b, sq_a, sq_b;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign full   = (fill_row_q == SIDE);

	// candidate letter for the square
	always_comb begin
		key_letter = (letter_first == LET_J) ? LET_I : letter_first;
		cand       = key_letter;
		cand_en    = 1'b0;
		if (state_q == ST_FILL) begin
			cand    = sweep_q;
			cand_en = (sweep_q != LET_J);
		end else if (accept && req_type == REQ_KEY) begin
			cand_en = (letter_first < LET_LIMIT) && !ready_q;
		end
		place.en     = cand_en && !full && !used_q[cand];
		place.letter = cand;
		place.row    = fill_row_q;
		place.col    = fill_col_q;
	end

	// pair letters after clamping, padding and j folding
	always_comb begin
		a_clamp = (letter_first < LET_LIMIT) ? letter_first : LET_Z;
		b_clamp = (letter_second < LET_LIMIT) ? letter_second : LET_Z;
		b_pad   = (!second_present || a_clamp == b_clamp) ? LET_X : b_clamp;
		a_addr  = (a_clamp == LET_J) ? LET_I : a_clamp;
		b_addr  = (b_pad == LET_J) ? LET_I : b_pad;
	end

	// row, column and rectangle rules on the looked-up positions
	always_comb begin
		if (pos_a.row == pos_b.row) begin
			sq_idx_a = cell_idx(pos_a.row, next_coord(pos_a.col));
			sq_idx_b = cell_idx(pos_b.row, next_coord(pos_b.col));
		end else if (pos_a.col == pos_b.col) begin
			sq_idx_a = cell_idx(next_coord(pos_a.row), pos_a.col);
			sq_idx_b = cell_idx(next_coord(pos_b.row), pos_b.col);
		end else begin
			sq_idx_a = cell_idx(pos_a.row, pos_b.col);
			sq_idx_b = cell_idx(pos_b.row, pos_a.col);
		end
	end

	pfe_store u_store (
		.clk        (clk),
		.place      (place),
		.pos_rd_en  (accept && req_type == REQ_PAIR),
		.pos_addr_a (a_addr),
		.pos_addr_b (b_addr),
		.pos_a      (pos_a),
		.pos_b      (pos_b),
		.sq_rd_en   (state_q == ST_POS),
		.sq_idx_a   (sq_idx_a),
		.sq_idx_b   (sq_idx_b),
		.sq_a       (sq_a),
		.sq_b       (sq_b)
	);

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_FINISH: state_next = ST_FILL;
						REQ_PAIR:   state_next = ready_q ? ST_POS : ST_IDLE;
						default:    state_next = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				if (sweep_q == LET_Z) state_next = ST_IDLE;
			end
			ST_POS:  state_next = ST_CELL;
			ST_CELL: state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sweep_q    <= '0;
			fill_row_q <= '0;
			fill_col_q <= '0;
			used_q     <= '0;
			ready_q    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept && req_type == REQ_FINISH) begin
				sweep_q <= '0;
			end else if (state_q == ST_FILL) begin
				sweep_q <= sweep_q + 5'd1;
			end
			if (state_q == ST_FILL && sweep_q == LET_Z) begin
				ready_q <= 1'b1;
			end
			if (place.en) begin
				used_q[place.letter] <= 1'b1;
				if (fill_col_q == SIDE_LAST) begin
					fill_col_q <= '0;
					fill_row_q <= fill_row_q + 3'd1;
				end else begin
					fill_col_q <= fill_col_q + 3'd1;
				end
			end
			done_q <= (accept && req_type == REQ_PAIR && !ready_q) || (state_q == ST_CELL);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_CELL) begin
			cipher_first_q  <= sq_a;
			cipher_second_q <= sq_b;
			status_q        <= 1'b0;
		end else if (accept && req_type == REQ_PAIR && !ready_q) begin
			cipher_first_q  <= '0;
			cipher_second_q <= '0;
			status_q        <= 1'b1;
		end
	end

	assign done          = done_q;
	assign cipher_first  = cipher_first_q;
	assign cipher_second = cipher_second_q;
	assign status        = status_q;

endmodule

`default_nettype wire

// File: rtl/pfe_store.sv
`default_nettype none

module pfe_store (
	input  logic             clk,
	input  pfe_pkg::place_t  place,
	input  logic             pos_rd_en,
	input  pfe_pkg::letter_t pos_addr_a,
	input  pfe_pkg::letter_t pos_addr_b,
	output pfe_pkg::pos_t    pos_a,
	output pfe_pkg::pos_t    pos_b,
	input  logic             sq_rd_en,
	input  pfe_pkg::letter_t sq_idx_a,
	input  pfe_pkg::letter_t sq_idx_b,
	output pfe_pkg::letter_t sq_a,
	output pfe_pkg::letter_t sq_b
);
	import pfe_pkg::*;

	letter_t square_mem [SQ_CELLS];
	pos_t    pos_mem [ALPHA_N];

	// single write port shared by key letters and the finish sweep
	always_ff @(posedge clk) begin
		if (place.en) begin
			square_mem[cell_idx(place.row, place.col)] <= place.letter;
			pos_mem[place.letter] <= '{row: place.row, col: place.col};
		end
	end

	// position lookup for both letters of a pair
	always_ff @(posedge clk) begin
		if (pos_rd_en) begin
			pos_a <= pos_mem[pos_addr_a];
			pos_b <= pos_mem[pos_addr_b];
		end
	end

	// cipher letter lookup
	always_ff @(posedge clk) begin
		if (sq_rd_en) begin
			sq_a <= square_mem[sq_idx_a];
			sq_b <= square_mem[sq_idx_b];
		end
	end

endmodule

`default_nettype wire

// File: rtl/pfe_check.sv
`default_nettype none

module pfe_check (
	input wire             clk,
	input wire             arst_n,
	input wire             start,
	input wire             busy,
	input pfe_pkg::req_t    req_type,
	input wire             done,
	input pfe_pkg::letter_t cipher_first,
	input pfe_pkg::letter_t cipher_second,
	input wire             status
);
	import pfe_pkg::*;

	// busy only starts from a taken item
	a_busy_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a taken item");

	// a not-ready result comes in the cycle after its pair is taken
	a_not_ready_timing: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> $past(start && !busy && req_type == REQ_PAIR))
		else $error("not-ready result without a pair item");

	// a cipher result follows its pair through the position read, square read and result register
	a_cipher_timing: assert property (@(posedge clk) disable iff (!arst_n)
		done && !status |-> $past(start && !busy && req_type == REQ_PAIR, 3))
		else $error("cipher result without a pair item");

	// not-ready results carry zero letters, cipher results carry real letters
	a_letters: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status && cipher_first == '0 && cipher_second == '0) ||
			(!status && cipher_first <= LET_Z && cipher_second <= LET_Z))
		else $error("result letters out of range");

endmodule

bind playfair_digraph_encrypt pfe_check u_pfe_check (.*);

`default_nettype wire
